>>> hw/rtl/aes_pkg.sv
package aes_pkg;

	localparam int BLK_W      = 128;
	localparam int HALF_W     = 64;
	localparam int NUM_ROUNDS = 10;
	localparam int CFG_IDX_W  = 8;
	localparam int KCNT_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

	localparam logic OP_DECRYPT = 1'b0;
	localparam logic OP_ENCRYPT = 1'b1;

	typedef logic [BLK_W-1:0] blk_t;
	typedef blk_t [NUM_ROUNDS:0] rkeys_t;

	typedef struct packed {
		logic op;
		blk_t blk;
	} entry_t;

	typedef struct packed {
		logic              busy;
		logic [KCNT_W-1:0] kround;
	} front_stat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
		8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
		8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
		8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
		8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
		8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
		8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
		8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
		8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
		8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
		8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
		8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
		8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
		8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
		8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
		8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
		8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] col);
		logic [7:0] a0, a1, a2, a3;
		a0 = col[31:24];
		a1 = col[23:16];
		a2 = col[15:8];
		a3 = col[7:0];
		return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
			xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
	endfunction

	function automatic logic [7:0] m9(input logic [7:0] a);
		return xt(xt(xt(a))) ^ a;
	endfunction

	function automatic logic [7:0] m11(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(a) ^ a;
	endfunction

	function automatic logic [7:0] m13(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
	endfunction

	function automatic logic [7:0] m14(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
		logic [7:0] a0, a1, a2, a3;
		a0 = col[31:24];
		a1 = col[23:16];
		a2 = col[15:8];
		a3 = col[7:0];
		return {m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3),
			m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3),
			m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3),
			m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3)};
	endfunction

	function automatic blk_t enc_round(input blk_t s, input blk_t rk, input logic last);
		blk_t t;
		blk_t m;
		int src;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = r + 4 * ((c + r) % 4);
				t[BLK_W-1-8*(r+4*c) -: 8] = SBOX[s[BLK_W-1-8*src -: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			m[BLK_W-1-32*c -: 32] = mix_col(t[BLK_W-1-32*c -: 32]);
		end
		return (last ? t : m) ^ rk;
	endfunction

	function automatic blk_t dec_round(input blk_t s, input blk_t rk, input logic last);
		blk_t t;
		blk_t m;
		int src;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = r + 4 * ((c - r + 4) % 4);
				t[BLK_W-1-8*(r+4*c) -: 8] = INV_SBOX[s[BLK_W-1-8*src -: 8]];
			end
		end
		t = t ^ rk;
		for (int c = 0; c < 4; c++) begin
			m[BLK_W-1-32*c -: 32] = inv_mix_col(t[BLK_W-1-32*c -: 32]);
		end
		return last ? t : m;
	endfunction

	function automatic logic [7:0] rcon(input logic [KCNT_W-1:0] n);
		logic [7:0] v;
		unique case (n)
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h04;
			4'd4:    v = 8'h08;
			4'd5:    v = 8'h10;
			4'd6:    v = 8'h20;
			4'd7:    v = 8'h40;
			4'd8:    v = 8'h80;
			4'd9:    v = 8'h1b;
			4'd10:   v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic blk_t key_step(input blk_t k, input logic [KCNT_W-1:0] n);
		logic [31:0] w0, w1, w2, w3, t, r;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		r  = {w3[23:0], w3[31:24]};
		t  = {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
		t  = t ^ {rcon(n), 24'h000000};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

>>> hw/rtl/aes128_block_cipher_top.sv
// AES-128 encrypt/decrypt, one 128-bit block per word, round keys held in registers.
// Path from input accept to result valid: input stage, queue, ten round stages.
// Throughput: one block per cycle outside key expansion; rounds stall only on output backpressure.
// A key register write re-expands the round keys, input held off meanwhile.
// Reset (arst_n low): key cleared to zero, pipeline and queue emptied, key expansion of the
// zero key runs after release.
module aes128_block_cipher_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [127:0]                  s_axis_tdata,  // block_low, block_high
	input  logic                          s_axis_tuser,  // operation
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [127:0]                  m_axis_tdata,  // result_low, result_high
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aes_pkg::HALF_W-1:0]    cfg_data
);
	import aes_pkg::*;

	logic        push, full, pop, not_empty;
	entry_t      push_entry, head;
	rkeys_t      rkeys;
	front_stat_t fstat;
	logic [1:0]  fcount;
	blk_t        out_blk;

	assign cfg_ready = 1'b1;

	aes_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_blk     ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.push_entry (push_entry),
		.rkeys      (rkeys),
		.stat       (fstat)
	);

	aes_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head),
		.count      (fcount)
	);

	aes_rounds u_rounds (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.rkeys     (rkeys),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_blk   (out_blk)
	);

	assign m_axis_tdata = {out_blk[63:0], out_blk[127:64]};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !fstat.busy)
		else $error("word accepted during key expansion");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW)
		|=> fstat.busy && fstat.kround == KCNT_W'(1))
		else $error("key write did not restart expansion");

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcount != 2'd3 && !(push && full) && !(pop && !not_empty))
		else $error("queue overflow or underflow");

endmodule

>>> hw/rtl/aes_front.sv
module aes_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_op,
	input  aes_pkg::blk_t                 in_blk,
	input  logic                          cfg_valid,
	input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aes_pkg::HALF_W-1:0]    cfg_data,
	output logic                          push,
	input  logic                          full,
	output aes_pkg::entry_t               push_entry,
	output aes_pkg::rkeys_t               rkeys,
	output aes_pkg::front_stat_t          stat
);
	import aes_pkg::*;

	logic [HALF_W-1:0] key_hi_q, key_lo_q;
	blk_t              prev_q;
	blk_t              rk_q [1:NUM_ROUNDS];
	logic              busy_q;
	logic [KCNT_W-1:0] kcnt_q;
	logic              v_s1;
	entry_t            ent_s1;
	logic              cfg_hit;
	logic              accept;
	blk_t              next_key;

	assign cfg_hit  = cfg_valid && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
	assign next_key = key_step(prev_q, kcnt_q);
	assign in_ready = !busy_q && (!v_s1 || !full);
	assign accept   = in_valid && in_ready;
	assign push     = v_s1 && !full;
	assign push_entry = ent_s1;
	assign stat.busy   = busy_q;
	assign stat.kround = kcnt_q;

	always_comb begin
		rkeys[0] = {key_hi_q, key_lo_q};
		for (int i = 1; i <= NUM_ROUNDS; i++) begin
			rkeys[i] = rk_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			prev_q   <= '0;
			busy_q   <= 1'b1;
			kcnt_q   <= KCNT_W'(1);
		end else if (cfg_hit) begin
			busy_q <= 1'b1;
			kcnt_q <= KCNT_W'(1);
			if (cfg_index == REG_KEY_HIGH) begin
				key_hi_q <= cfg_data;
				prev_q   <= {cfg_data, key_lo_q};
			end else begin
				key_lo_q <= cfg_data;
				prev_q   <= {key_hi_q, cfg_data};
			end
		end else if (busy_q) begin
			prev_q <= next_key;
			kcnt_q <= kcnt_q + KCNT_W'(1);
			if (kcnt_q == KCNT_W'(NUM_ROUNDS)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_hit) begin
			rk_q[kcnt_q] <= next_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	// fold in the first round key by direction
	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1.op  <= in_op;
			ent_s1.blk <= in_blk ^ ((in_op == OP_ENCRYPT) ? rkeys[0] : rkeys[NUM_ROUNDS]);
		end
	end

endmodule

>>> hw/rtl/aes_fifo.sv
module aes_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  aes_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output aes_pkg::entry_t head,
	output logic [1:0]      count
);
	import aes_pkg::*;

	entry_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = mem_q[rd_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hw/rtl/aes_rounds.sv
module aes_rounds (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  aes_pkg::entry_t head,
	output logic            pop,
	input  aes_pkg::rkeys_t rkeys,
	output logic            out_valid,
	input  logic            out_ready,
	output aes_pkg::blk_t   out_blk
);
	import aes_pkg::*;

	logic vld_s [NUM_ROUNDS];
	logic op_s  [NUM_ROUNDS];
	blk_t blk_s [NUM_ROUNDS];
	logic adv;

	assign adv       = !vld_s[NUM_ROUNDS-1] || out_ready;
	assign pop       = adv && not_empty;
	assign out_valid = vld_s[NUM_ROUNDS-1];
	assign out_blk   = blk_s[NUM_ROUNDS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ROUNDS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= not_empty;
			for (int k = 1; k < NUM_ROUNDS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s[0] <= head.op;
			blk_s[0] <= (head.op == OP_ENCRYPT)
				? enc_round(head.blk, rkeys[1], 1'b0)
				: dec_round(head.blk, rkeys[NUM_ROUNDS-1], 1'b0);
			for (int k = 1; k < NUM_ROUNDS; k++) begin
				op_s[k] <= op_s[k-1];
				blk_s[k] <= (op_s[k-1] == OP_ENCRYPT)
					? enc_round(blk_s[k-1], rkeys[k+1], k == NUM_ROUNDS - 1)
					: dec_round(blk_s[k-1], rkeys[NUM_ROUNDS-1-k], k == NUM_ROUNDS - 1);
			end
		end
	end

endmodule

>>> dv/tb_aes128_block_cipher_top.sv
module tb_aes128_block_cipher_top;
	import aes_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAST  = 8'hff;

	typedef struct {
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
	} cipher_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [127:0]         s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [127:0]         m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [HALF_W-1:0]    cfg_data = '0;

	cipher_word_t      cipher_q[$];
	logic [HALF_W-1:0] key_hi = '0;
	logic [HALF_W-1:0] key_lo = '0;
	logic [7:0]        fwd_box[256];
	logic [7:0]        rev_box[256];
	logic [7:0]        st[16];
	int                err_count = 0;
	int                cycles = 0;
	bit                tx_slack = 1'b1;
	bit                rx_slack = 1'b1;

	aes128_block_cipher_top DUT (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_aes128_block_cipher_top: done, errors");
			$finish;
		end
	end

	function automatic logic [7:0] gf_x2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = gf_x2(a);
		end
		return acc;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	function void build_boxes();
		logic [7:0] inv;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			inv = (x == 0) ? 8'h00 : 8'h01;
			if (x != 0)
				for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
			s = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ 8'h63;
			fwd_box[x] = s;
			rev_box[s] = x[7:0];
		end
	endfunction

	function void sub_state(input bit rev);
		for (int i = 0; i < 16; i++) st[i] = rev ? rev_box[st[i]] : fwd_box[st[i]];
	endfunction

	function void shift_state(input bit rev);
		logic [7:0] t[16];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[r + 4 * c] = st[r + 4 * (rev ? ((c - r + 4) & 3) : ((c + r) & 3))];
		st = t;
	endfunction

	function void mix_state(input bit rev);
		logic [7:0] m[4];
		logic [7:0] col[4];
		logic [7:0] acc;
		if (rev) begin
			m = '{8'd14, 8'd11, 8'd13, 8'd9};
		end else begin
			m = '{8'd2, 8'd3, 8'd1, 8'd1};
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) col[r] = st[4 * c + r];
			for (int r = 0; r < 4; r++) begin
				acc = '0;
				for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], m[(k - r + 4) & 3]);
				st[4 * c + r] = acc;
			end
		end
	endfunction

	function void xor_state(input logic [127:0] rk);
		for (int i = 0; i < 16; i++) st[i] ^= rk[127 - 8 * i -: 8];
	endfunction

	function cipher_word_t aes_predict(input logic op, input logic [127:0] blk);
		logic [31:0]  w[44];
		logic [31:0]  t;
		logic [7:0]   rc;
		logic [127:0] rk[11];
		logic [127:0] res;
		cipher_word_t out;
		w[0] = key_hi[63:32];
		w[1] = key_hi[31:0];
		w[2] = key_lo[63:32];
		w[3] = key_lo[31:0];
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			t = w[i - 1];
			if ((i & 3) == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
				t ^= {rc, 24'h0};
				rc = gf_x2(rc);
			end
			w[i] = w[i - 4] ^ t;
		end
		for (int r = 0; r < 11; r++) rk[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
		for (int i = 0; i < 16; i++) st[i] = blk[127 - 8 * i -: 8];
		if (op == OP_ENCRYPT) begin
			xor_state(rk[0]);
			for (int r = 1; r < 10; r++) begin
				sub_state(1'b0);
				shift_state(1'b0);
				mix_state(1'b0);
				xor_state(rk[r]);
			end
			sub_state(1'b0);
			shift_state(1'b0);
			xor_state(rk[10]);
		end else begin
			xor_state(rk[10]);
			shift_state(1'b1);
			sub_state(1'b1);
			for (int r = 9; r >= 1; r--) begin
				xor_state(rk[r]);
				mix_state(1'b1);
				shift_state(1'b1);
				sub_state(1'b1);
			end
			xor_state(rk[0]);
		end
		for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
		out.hi = res[127:64];
		out.lo = res[63:0];
		return out;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		err_count++;
	endtask

	// tvalid stays high on return so a zero-gap word can follow in the same step
	task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
		int gap;
		gap = tx_slack ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {lo, hi};
		do @(posedge clk); while (!s_axis_tready);
		cipher_q.push_back(aes_predict(op, {hi, lo}));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (cipher_q.size() > 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_KEY_HIGH) key_hi = val;
		else if (idx == REG_KEY_LOW) key_lo = val;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		int stall;
		cipher_word_t want;
		@(posedge arst_n);
		forever begin
			stall = rx_slack ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (cipher_q.size() == 0) begin
				report("unexpected word", m_axis_tdata[63:0], '0);
			end else begin
				want = cipher_q.pop_front();
				if (m_axis_tdata[63:0] !== want.hi) report("result_high", m_axis_tdata[63:0], want.hi);
				if (m_axis_tdata[127:64] !== want.lo) report("result_low", m_axis_tdata[127:64], want.lo);
			end
		end
	end

	task automatic test_reset_key();
		send_block(OP_ENCRYPT, '0, '0);
		send_block(OP_DECRYPT, '0, '0);
		send_block(OP_ENCRYPT, '1, '1);
		send_block(OP_DECRYPT, '1, '1);
		send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
		drain();
	endtask

	task automatic test_known_vector();
		write_reg(REG_KEY_HIGH, 64'h0001020304050607);
		write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		send_block(OP_ENCRYPT, '1, '0);
		send_block(OP_DECRYPT, '0, '1);
		write_reg(REG_SPARE, '1);
		write_reg(REG_LAST, 64'h0123456789abcdef);
		send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(OP_DECRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		drain();
	endtask

	task automatic test_key_extremes();
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_KEY_LOW, '1);
		send_block(OP_ENCRYPT, '0, '0);
		send_block(OP_DECRYPT, '1, '1);
		write_reg(REG_KEY_HIGH, '0);
		send_block(OP_ENCRYPT, '1, '0);
		send_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
		drain();
	endtask

	// encrypt a block and decrypt its ciphertext back, or send a block of random op
	task automatic test_random_phase(input int words, input bit pause_mid);
		cipher_word_t ct;
		logic [63:0] hi, lo;
		for (int i = 0; i < words; i++) begin
			hi = rand64();
			lo = rand64();
			if ($urandom_range(0, 3) != 0) begin
				ct = aes_predict(OP_ENCRYPT, {hi, lo});
				send_block(OP_ENCRYPT, hi, lo);
				send_block(OP_DECRYPT, ct.hi, ct.lo);
				i++;
			end else begin
				send_block(1'($urandom_range(0, 1)), hi, lo);
			end
			if (pause_mid && i == words / 2) drain();
		end
		drain();
	endtask

	initial begin
		build_boxes();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_key();
		test_known_vector();
		test_key_extremes();
		for (int p = 0; p < 5; p++) begin
			tx_slack = (p != 1) && (p != 3);
			rx_slack = (p != 1) && (p != 2);
			case (p)
				0: begin
					write_reg(REG_KEY_HIGH, '1);
					write_reg(REG_KEY_LOW, '1);
				end
				1: begin
					write_reg(REG_KEY_HIGH, '0);
					write_reg(REG_KEY_LOW, '0);
				end
				default: begin
					write_reg(REG_KEY_HIGH, rand64());
					write_reg(REG_KEY_LOW, rand64());
				end
			endcase
			test_random_phase(190, p == 2);
		end
		drain();
		if (err_count == 0) begin
			$display("tb_aes128_block_cipher_top: done, clean");
		end else begin
			$display("tb_aes128_block_cipher_top: done, errors");
		end
		$finish;
	end

endmodule
